// ===== rtl/core/kcp_pkg.sv =====
// Shared types, constants and microcode for the keypad calculator core.
// Used by every module under rtl/core; depends on nothing.
package kcp_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int PC_W = 4;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [1:0] {
      KEY_DIGIT    = 2'd0,
      KEY_OPERATOR = 2'd1,
      KEY_EQUALS   = 2'd2,
      KEY_CLEAR    = 2'd3
   } key_type;

   typedef enum logic [1:0] {
      OPC_PLUS  = 2'd0,
      OPC_MINUS = 2'd1,
      OPC_MUL   = 2'd2,
      OPC_DIV   = 2'd3
   } opc_type;

   typedef enum logic [1:0] {
      MUL_NONE   = 2'd0,
      MUL_TIMES  = 2'd1,
      MUL_DIVIDE = 2'd2
   } mulop_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_DIGIT,
      UOP_TERM_ENTRY,
      UOP_TERM_MUL,
      UOP_DIV_START,
      UOP_TERM_QUOT,
      UOP_SET_PROD,
      UOP_ADD_TERM,
      UOP_EQUALS,
      UOP_CLEAR
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_MUL_NONE,
      COND_MUL_TIMES,
      COND_DIV_BUSY,
      COND_KEY_EQUALS,
      COND_OPC_ADDSUB
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      pc_type   target;
      logic     last;
   } ucode_type;

   typedef struct packed {
      logic    exec;
      logic    last;
      uop_type uop;
   } ctl_type;

   typedef struct packed {
      logic mul_none;
      logic mul_times;
      logic div_busy;
      logic key_equals;
      logic opc_addsub;
   } stat_type;

   typedef struct packed {
      value_type shown;
      logic      ready;
      logic      error;
   } res_type;

   localparam pc_type PC_DIGIT    = pc_type'(0);
   localparam pc_type PC_CLOSE    = pc_type'(1);
   localparam pc_type PC_DIV_WAIT = pc_type'(4);
   localparam pc_type PC_SORT     = pc_type'(6);
   localparam pc_type PC_ADDSUB   = pc_type'(9);
   localparam pc_type PC_EQUALS   = pc_type'(10);
   localparam pc_type PC_CLEAR    = pc_type'(11);

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      w = '{uop: UOP_NOP, cond: COND_NEVER, target: PC_DIGIT, last: 1'b1};
      unique case (pc)
         pc_type'(0):  w = '{UOP_DIGIT,      COND_NEVER,      PC_DIGIT,    1'b1};
         pc_type'(1):  w = '{UOP_TERM_ENTRY, COND_MUL_NONE,   PC_SORT,     1'b0};
         pc_type'(2):  w = '{UOP_TERM_MUL,   COND_MUL_TIMES,  PC_SORT,     1'b0};
         pc_type'(3):  w = '{UOP_DIV_START,  COND_NEVER,      PC_DIGIT,    1'b0};
         pc_type'(4):  w = '{UOP_NOP,        COND_DIV_BUSY,   PC_DIV_WAIT, 1'b0};
         pc_type'(5):  w = '{UOP_TERM_QUOT,  COND_NEVER,      PC_DIGIT,    1'b0};
         pc_type'(6):  w = '{UOP_NOP,        COND_KEY_EQUALS, PC_EQUALS,   1'b0};
         pc_type'(7):  w = '{UOP_NOP,        COND_OPC_ADDSUB, PC_ADDSUB,   1'b0};
         pc_type'(8):  w = '{UOP_SET_PROD,   COND_NEVER,      PC_DIGIT,    1'b1};
         pc_type'(9):  w = '{UOP_ADD_TERM,   COND_NEVER,      PC_DIGIT,    1'b1};
         pc_type'(10): w = '{UOP_EQUALS,     COND_NEVER,      PC_DIGIT,    1'b1};
         pc_type'(11): w = '{UOP_CLEAR,      COND_NEVER,      PC_DIGIT,    1'b1};
         default:      w = '{UOP_NOP,        COND_NEVER,      PC_DIGIT,    1'b1};
      endcase
      return w;
   endfunction

   function automatic pc_type entry_point(input key_type key);
      pc_type pc;
      pc = PC_DIGIT;
      unique case (key)
         KEY_DIGIT:    pc = PC_DIGIT;
         KEY_OPERATOR: pc = PC_CLOSE;
         KEY_EQUALS:   pc = PC_CLOSE;
         KEY_CLEAR:    pc = PC_CLEAR;
         default:      pc = PC_CLEAR;
      endcase
      return pc;
   endfunction

endpackage

// ===== rtl/core/kcp_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on kcp_pkg for the value width.
module kcp_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  kcp_pkg::value_type dividend,
   input  kcp_pkg::value_type divisor,
   output logic              busy,
   output kcp_pkg::value_type quotient,
   output logic              divide_by_zero
);
   import kcp_pkg::*;

   logic [COUNT_W-1:0]   count_ff, count_in;
   value_type            quo_ff, quo_in;
   value_type            rem_ff, rem_in;
   value_type            dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [VALUE_WIDTH:0] rem_shift;
   logic [VALUE_WIDTH:0] diff;

   assign busy           = (count_ff != '0);
   assign divide_by_zero = zero_ff;
   assign quotient       = zero_ff ? '0 : (neg_ff ? (~quo_ff + 1'b1) : quo_ff);

   always_comb begin
      rem_shift = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff      = rem_shift - {1'b0, dvs_ff};
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      if (start) begin
         count_in = COUNT_W'(VALUE_WIDTH);
         quo_in   = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
         dvs_in   = divisor[VALUE_WIDTH-1] ? (~divisor + 1'b1) : divisor;
         rem_in   = '0;
         neg_in   = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
         zero_in  = (divisor == '0);
      end else if (busy) begin
         count_in = count_ff - COUNT_W'(1);
         if (diff[VALUE_WIDTH]) begin
            rem_in = rem_shift[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end else begin
            rem_in = diff[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

endmodule

// ===== rtl/core/kcp_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on kcp_pkg for the control store and the control and status structs.
module kcp_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  kcp_pkg::key_type  start_key,
   input  kcp_pkg::stat_type stat,
   input  logic              out_blocked,
   output kcp_pkg::ctl_type  ctl,
   output logic              busy
);
   import kcp_pkg::*;

   pc_type    pc_ff, pc_in;
   logic      busy_ff, busy_in;
   ucode_type word;
   logic      taken;
   logic      exec;

   assign busy = busy_ff;

   always_comb begin
      word = ucode_rom(pc_ff);
      exec = busy_ff && !(word.last && out_blocked);
      unique case (word.cond)
         COND_NEVER:      taken = 1'b0;
         COND_MUL_NONE:   taken = stat.mul_none;
         COND_MUL_TIMES:  taken = stat.mul_times;
         COND_DIV_BUSY:   taken = stat.div_busy;
         COND_KEY_EQUALS: taken = stat.key_equals;
         COND_OPC_ADDSUB: taken = stat.opc_addsub;
         default:         taken = 1'b0;
      endcase
      ctl.exec = exec;
      ctl.last = word.last;
      ctl.uop  = word.uop;
      pc_in    = pc_ff;
      busy_in  = busy_ff;
      if (start) begin
         pc_in   = entry_point(start_key);
         busy_in = 1'b1;
      end else if (exec) begin
         pc_in = taken ? word.target : pc_ff + 1'b1;
         if (word.last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_DIGIT;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== rtl/core/kcp_datapath.sv =====
// Calculator datapath: entry, product term, running sum, pending operators, error flag.
// Depends on kcp_pkg, kcp_divider; kcp_sequencer issues a uop per cycle unless held.
module kcp_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_key,
   input  kcp_pkg::key_type  key_kind,
   input  logic [3:0]        key_digit,
   input  kcp_pkg::opc_type  key_opc,
   input  kcp_pkg::ctl_type  ctl,
   output kcp_pkg::stat_type stat,
   output kcp_pkg::res_type  res
);
   import kcp_pkg::*;

   value_type   entry_ff, entry_in;
   value_type   prod_ff, prod_in;
   value_type   sum_ff, sum_in;
   value_type   term_ff, term_in;
   mulop_type   mulop_ff, mulop_in;
   logic        sub_ff, sub_in;
   logic        err_ff, err_in;
   key_type     kind_ff;
   logic [3:0]  digit_ff;
   opc_type     opc_ff;
   value_type   mul_low;
   value_type   digit_next;
   value_type   add_sum;
   value_type   quotient;
   logic        div_busy;
   logic        div_zero;
   logic        div_start;

   assign div_start = ctl.exec && (ctl.uop == UOP_DIV_START);

   kcp_divider u_divider (
      .clock          (clock),
      .reset          (reset),
      .start          (div_start),
      .dividend       (prod_ff),
      .divisor        (entry_ff),
      .busy           (div_busy),
      .quotient       (quotient),
      .divide_by_zero (div_zero)
   );

   assign mul_low    = prod_ff * entry_ff;
   assign digit_next = {entry_ff[VALUE_WIDTH-4:0], 3'b000} + {entry_ff[VALUE_WIDTH-2:0], 1'b0}
                       + value_type'(digit_ff);
   assign add_sum    = sub_ff ? (sum_ff - term_ff) : (sum_ff + term_ff);

   always_comb begin
      stat.mul_none   = (mulop_ff == MUL_NONE);
      stat.mul_times  = (mulop_ff == MUL_TIMES);
      stat.div_busy   = div_busy;
      stat.key_equals = (kind_ff == KEY_EQUALS);
      stat.opc_addsub = (opc_ff == OPC_PLUS) || (opc_ff == OPC_MINUS);
   end

   always_comb begin
      entry_in  = entry_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      term_in   = term_ff;
      mulop_in  = mulop_ff;
      sub_in    = sub_ff;
      err_in    = err_ff;
      res.shown = '0;
      res.ready = 1'b0;
      if (ctl.exec) begin
         unique case (ctl.uop)
            UOP_NOP: begin
            end
            UOP_DIV_START: begin
            end
            UOP_DIGIT: begin
               entry_in  = digit_next;
               res.shown = digit_next;
            end
            UOP_TERM_ENTRY: begin
               term_in = entry_ff;
            end
            UOP_TERM_MUL: begin
               term_in = mul_low;
            end
            UOP_TERM_QUOT: begin
               term_in = quotient;
               err_in  = err_ff | div_zero;
            end
            UOP_SET_PROD: begin
               prod_in   = term_ff;
               mulop_in  = (opc_ff == OPC_MUL) ? MUL_TIMES : MUL_DIVIDE;
               entry_in  = '0;
               res.shown = term_ff;
            end
            UOP_ADD_TERM: begin
               sum_in    = add_sum;
               sub_in    = (opc_ff == OPC_MINUS);
               prod_in   = '0;
               mulop_in  = MUL_NONE;
               entry_in  = '0;
               res.shown = add_sum;
            end
            UOP_EQUALS: begin
               entry_in  = add_sum;
               prod_in   = '0;
               sum_in    = '0;
               mulop_in  = MUL_NONE;
               sub_in    = 1'b0;
               res.shown = add_sum;
               res.ready = 1'b1;
            end
            UOP_CLEAR: begin
               entry_in = '0;
               prod_in  = '0;
               sum_in   = '0;
               mulop_in = MUL_NONE;
               sub_in   = 1'b0;
               err_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
      res.error = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         prod_ff  <= '0;
         sum_ff   <= '0;
         mulop_ff <= MUL_NONE;
         sub_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         prod_ff  <= prod_in;
         sum_ff   <= sum_in;
         mulop_ff <= mulop_in;
         sub_ff   <= sub_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      if (load_key) begin
         kind_ff  <= key_kind;
         digit_ff <= key_digit;
         opc_ff   <= key_opc;
      end
   end

endmodule

// ===== rtl/core/keypad_calculator_precedence_core.sv =====
// Keypad calculator with * and / binding tighter than + and -, 32-bit wrapping.
// Input words carry one key press; every key yields exactly one result word.
// The req channel takes a word whenever the sequencer is idle. tuser holds the
// key kind (digit, operator, equals, clear), tdata the digit and operator code.
// The rsp channel returns the value on show in tdata, and in tuser the flag
// that marks a completed evaluation and the sticky division-by-zero flag.
// An operator or equals closes the pending term, then sets the product, adds
// the term to the sum or finishes the evaluation; a pending division is closed
// through the shift-subtract divider, which yields one quotient bit per cycle.
// A new key is taken in the cycle after the last micro-step of the previous
// one, so no key is taken while the previous one is still being processed.
// The result register frees the sequencer: a word may be accepted while a
// result waits. If the receiver stalls, the final micro-step of the next key
// holds until the waiting result is taken. Reset returns the calculator to
// the cleared state (entry, product, sum and error all zero) and drops tvalid.
// Depends on kcp_pkg, kcp_sequencer, kcp_datapath and kcp_divider.
module keypad_calculator_precedence_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] digit, [5:4] operator_code, [7:6] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] shown_value
   output logic [1:0]  rsp_tuser    // [0] result_ready, [1] divide_error
);
   import kcp_pkg::*;

   ctl_type   ctl;
   stat_type  stat;
   res_type   res;
   logic      seq_busy;
   logic      req_accept;
   logic      out_blocked;
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff;
   logic      rsp_ready_ff;
   logic      rsp_error_ff;

   assign req_tready  = !seq_busy;
   assign req_accept  = req_tvalid && req_tready;
   assign out_blocked = rsp_valid_ff && !rsp_tready;

   kcp_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .start_key   (key_type'(req_tuser)),
      .stat        (stat),
      .out_blocked (out_blocked),
      .ctl         (ctl),
      .busy        (seq_busy)
   );

   kcp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .load_key  (req_accept),
      .key_kind  (key_type'(req_tuser)),
      .key_digit (req_tdata[3:0]),
      .key_opc   (opc_type'(req_tdata[5:4])),
      .ctl       (ctl),
      .stat      (stat),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.exec && ctl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec && ctl.last) begin
         rsp_value_ff <= res.shown;
         rsp_ready_ff <= res.ready;
         rsp_error_ff <= res.error;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_error_ff, rsp_ready_ff};

`ifndef SYNTHESIS
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(seq_busy))
      else $error("result word raised without an active key");

   a_divider_within_key: assert property (@(posedge clock) disable iff (reset)
      stat.div_busy |-> seq_busy)
      else $error("divider running while sequencer idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl.exec && ctl.last) |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten while stalled");
`endif

endmodule
